### src/sha256_pkg.sv
// Package: shared types, constants and functions of the SHA-256 stream hasher.
`default_nettype none
package sha256_pkg;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  word_index;
    logic [31:0] digest_word;
    logic        last;
  } out_beat_t;

  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [7:0][31:0] hash_t;

  localparam hash_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### src/sha256_front.sv
// Front end: input queue that holds accepted beats until the back end takes them.
`default_nettype none
module sha256_front #(
  parameter int DEPTH_LG = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire sha256_pkg::in_beat_t push_beat,
  output logic                     full,
  input  wire logic                take,
  output logic                     avail,
  output sha256_pkg::in_beat_t     head
);
  localparam int DEPTH = 1 << DEPTH_LG;

  sha256_pkg::in_beat_t mem [DEPTH];
  logic [DEPTH_LG-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [DEPTH_LG:0]   cnt_r, cnt_nxt;
  logic do_push, do_take;

  assign full    = (cnt_r == (DEPTH_LG+1)'(DEPTH));
  assign avail   = (cnt_r != '0);
  assign head    = mem[rp_r];
  assign do_push = push && !full;
  assign do_take = take && avail;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_take ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (DEPTH_LG+1)'(do_push) - (DEPTH_LG+1)'(do_take);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

### src/sha256_back.sv
// Back end: block buffer, padding sequencer, one-round-per-cycle compression, digest out.
`default_nettype none
module sha256_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 avail,
  input  wire sha256_pkg::in_beat_t head,
  output logic                      take,
  output logic                      out_valid,
  output sha256_pkg::out_beat_t     out_beat,
  input  wire logic                 out_take
);
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_PAD  = 6'b000100,
    ST_RND  = 6'b001000,
    ST_ADD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  buf_mem [64];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  sha256_pkg::hash_t hash_r, hash_nxt;
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  rnd_r, rnd_nxt;
  logic [5:0]  ptr_r, ptr_nxt;     // byte pointer for load and pad
  logic        fin_r, fin_nxt;     // compression belongs to a finish
  logic        two_r, two_nxt;     // another padding block follows
  logic [2:0]  oidx_r, oidx_nxt;
  logic [7:0]  rd_r;

  logic        buf_we;
  logic [5:0]  buf_wa;
  logic [7:0]  buf_wd;
  logic [31:0] w_new, w_cur, t1, t2, s0, s1, bs0, bs1, ch, maj;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // schedule word and round terms for this round
  always_comb begin
    s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    w_cur = (rnd_r < 6'd16) ? w_r[0] : w_new;
    bs1 = ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25);
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1  = v_r[7] + bs1 + ch + sha256_pkg::round_k(rnd_r) + w_cur;
    bs0 = ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2  = bs0 + maj;
  end

  // padding byte at ptr_r
  function automatic logic [7:0] pad_byte(input logic [5:0] p, input logic [5:0] f,
                                          input logic first, input logic last_blk,
                                          input logic [63:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (first && p == f) d = sha256_pkg::PAD_BYTE;
    else if (last_blk && p >= 6'd56) d = b[8*(7 - (p - 6'd56)) +: 8];
    return d;
  endfunction

  logic pad_first_r, pad_first_nxt;

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r; bits_nxt = bits_r; hash_nxt = hash_r;
    rnd_nxt = rnd_r; ptr_nxt = ptr_r; fin_nxt = fin_r; two_nxt = two_r;
    oidx_nxt = oidx_r; pad_first_nxt = pad_first_r;
    take = 1'b0; buf_we = 1'b0; buf_wa = ptr_r; buf_wd = 8'h00;
    unique case (state_r)
      ST_IDLE: begin
        if (avail) begin
          take = 1'b1;
          if (head.mode == sha256_pkg::MODE_ABSORB) begin
            buf_we = 1'b1; buf_wa = fill_r; buf_wd = head.data_byte;
            bits_nxt = bits_r + 64'd8;
            fill_nxt = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              fin_nxt = 1'b0; ptr_nxt = '0; state_nxt = ST_LOAD;
            end
          end else begin
            fin_nxt = 1'b1; ptr_nxt = fill_r; pad_first_nxt = 1'b1;
            two_nxt = (fill_r >= 6'd56);
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        buf_we = 1'b1;
        buf_wd = pad_byte(ptr_r, fill_r, pad_first_r, !two_r, bits_r);
        ptr_nxt = ptr_r + 6'd1;
        if (ptr_r == 6'd63) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // read one byte per cycle into the schedule window (registered buffer read)
        ptr_nxt = ptr_r + 6'd1;
        if (ptr_r == 6'd0 && rnd_r == 6'd1) begin
          rnd_nxt = '0; state_nxt = ST_RND;
        end else if (ptr_r == 6'd0 && rnd_r == 6'd0) begin
          rnd_nxt = 6'd1;
        end
      end
      ST_RND: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        for (int j = 0; j < 8; j++) hash_nxt[j] = hash_r[j] + v_r[j];
        if (!fin_r) begin
          fill_nxt = '0; state_nxt = ST_IDLE;
        end else if (two_r) begin
          two_nxt = 1'b0; pad_first_nxt = 1'b0; ptr_nxt = '0; state_nxt = ST_PAD;
        end else begin
          oidx_nxt = '0; state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_take) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            hash_nxt = sha256_pkg::INIT_HASH; fill_nxt = '0; bits_nxt = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // load sequencing: rnd_r==0 marks the priming read at ptr 0, then ptr wraps through 64 reads
  logic load_prime_r;

  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_wa] <= buf_wd;
    rd_r <= buf_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    load_prime_r <= (state_r == ST_LOAD);
    if (state_r == ST_LOAD && load_prime_r) begin
      // shift byte into the schedule window as a 512-bit shift line
      for (int j = 0; j < 15; j++) w_r[j] <= {w_r[j][23:0], w_r[j+1][31:24]};
      w_r[15] <= {w_r[15][23:0], rd_r};
    end else if (state_r == ST_RND) begin
      for (int j = 0; j < 15; j++) w_r[j] <= w_r[j+1];
      w_r[15] <= w_cur;
    end
    if (state_r == ST_LOAD) begin
      for (int j = 0; j < 8; j++) v_r[j] <= hash_r[j];
    end else if (state_r == ST_RND) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; fill_r <= '0; bits_r <= '0; hash_r <= sha256_pkg::INIT_HASH;
      rnd_r <= '0; ptr_r <= '0; fin_r <= 1'b0; two_r <= 1'b0; oidx_r <= '0;
      pad_first_r <= 1'b0;
    end else begin
      state_r <= state_nxt; fill_r <= fill_nxt; bits_r <= bits_nxt; hash_r <= hash_nxt;
      rnd_r <= rnd_nxt; ptr_r <= ptr_nxt; fin_r <= fin_nxt; two_r <= two_nxt;
      oidx_r <= oidx_nxt; pad_first_r <= pad_first_nxt;
    end
  end

  assign out_valid = (state_r == ST_OUT);
  assign out_beat.word_index  = oidx_r;
  assign out_beat.digest_word = hash_r[oidx_r];
  assign out_beat.last        = (oidx_r == 3'd7);
endmodule
`default_nettype wire

### src/sha256_stream_hasher_core.sv
// Top level of the SHA-256 stream hasher: input queue plus hashing back end.
//
// Usage:
//   Input channel: drive in_beat (mode, data_byte) and raise push while full is
//   low; each such edge takes one beat. Mode 0 beats absorb one message byte;
//   a mode 1 beat closes the message and yields eight digest beats.
//   Result channel: while empty is low, out_beat holds digest word word_index
//   (H0 first), last marks word 7; raise pop to take it.
//   Processing: an absorb beat is taken in the idle state; every 64th byte
//   adds a block pass: a byte load of the message schedule through the single
//   buffer read port, 64 rounds of the one round unit and a chaining add. No
//   beat is taken during a block pass. A finish writes the padding bytes, runs
//   one or two block passes, then shows eight words.
//   Until full, the input queue keeps accepting beats while the back end is busy or
//   the receiver stalls; a stalled receiver freezes the digest word on the ports.
//   Reset (rst_n low at a clock edge) empties the queue and restores the
//   initial hash values, fill count and bit count. The block buffer needs no clear.
`default_nettype none
module sha256_stream_hasher_core #(
  parameter int QUEUE_LG = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire sha256_pkg::in_beat_t in_beat,
  output logic                      full,
  output logic                      empty,
  input  wire logic                 pop,
  output sha256_pkg::out_beat_t     out_beat
);
  logic avail, take, out_valid;
  sha256_pkg::in_beat_t head;

  sha256_front #(.DEPTH_LG(QUEUE_LG)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .push_beat(in_beat), .full(full),
    .take(take), .avail(avail), .head(head)
  );

  sha256_back u_back (
    .clk(clk), .rst_n(rst_n), .avail(avail), .head(head), .take(take),
    .out_valid(out_valid), .out_beat(out_beat), .out_take(pop)
  );

  assign empty = !out_valid;

`ifndef SYNTH
  // hold a waiting digest word while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_beat)))
    else $error("digest beat changed while stalled");
  // last flag marks word seven only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_beat.last == (out_beat.word_index == 3'd7)))
    else $error("last flag mismatch");
`endif
endmodule
`default_nettype wire
